### rtl/kmc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmc_pkg
// shared types and codes of the k-mer support and markov counter
// ---------------------------------------------------------------------------
package kmc_pkg;

  localparam int REQ_W   = 3;
  localparam int SYM_W   = 5;
  localparam int IDX_W   = 16;
  localparam int VAL_W   = 40;
  localparam int OVF_W   = 32;
  localparam int SUP_W   = 16;
  localparam int CNT32_W = 32;
  localparam int SEQ_W   = 16;
  localparam int CFG_W   = 6;
  localparam int CFGA_W  = 2;

  localparam logic [REQ_W-1:0] REQ_SYMBOL  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SUPPORT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CONTEXT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TRANS   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TOTALS  = 3'd4;

  localparam logic [CFGA_W-1:0] CFG_ALPHABET = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_SEEDLEN  = 2'd1;
  localparam logic [CFGA_W-1:0] CFG_ORDER    = 2'd2;

  typedef enum logic [1:0] {
    PH_SEED = 2'd0,
    PH_CTX  = 2'd1,
    PH_TR   = 2'd2
  } phase_t;

  typedef struct packed {
    logic   clr_step;
    logic   take_sym;
    logic   rd_req;
    logic   walk_start;
    logic   walk_step;
    logic   ovf_bump;
    logic   tbl_rd;
    logic   tbl_wr;
    logic   out_load;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic req_sym;
    logic req_read;
    logic sym_ok;
    logic need_seed;
    logic need_ctx;
    logic need_tr;
    logic walk_hit;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/kmer_support_markov_counter_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmer_support_markov_counter_top
// k-mer seed support with per-sequence dedup and order-k markov counts
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_tvalid/tready   tdata: symbol, table_index; tuser: req_type, first
// out      out  out_tvalid/tready  tdata: read_value, overflow_total
// cfg      in   cfg_we             cfg_addr, cfg_wdata
//
// after reset a clearing pass zeroes all tables, stepping through the largest
// table depth (65536 by default); items wait, cfg writes are taken
// symbol: per phase (seed_length, markov_order, markov_order + 1) the code is built
// and its entry read and written back; a phase is skipped while the window is short
// and cut short when the code leaves its table; a symbol not below the clamped
// alphabet size runs no phase; read: registered table ports, waits if out stalls
// a finished result waits in the output register while a symbol is taken
// ---------------------------------------------------------------------------
module kmer_support_markov_counter_top
  import kmc_pkg::*;
#(
  parameter int SEED_TABLE_DEPTH       = 65536,
  parameter int CONTEXT_TABLE_DEPTH    = 1024,
  parameter int TRANSITION_TABLE_DEPTH = 1024,
  parameter int MAX_SEED_LENGTH        = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFGA_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // symbol, table_index, zero pad
  input  logic [3:0]        in_tuser,   // req_type, first_of_sequence
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata   // read_value, overflow_total
);

  cmd_t cmd;
  sts_t sts;
  logic [VAL_W-1:0] read_value;
  logic [OVF_W-1:0] overflow_total;

  kmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kmc_datapath #(
    .SEED_TABLE_DEPTH       (SEED_TABLE_DEPTH),
    .CONTEXT_TABLE_DEPTH    (CONTEXT_TABLE_DEPTH),
    .TRANSITION_TABLE_DEPTH (TRANSITION_TABLE_DEPTH),
    .MAX_SEED_LENGTH        (MAX_SEED_LENGTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .req_type          (in_tuser[2:0]),
    .symbol            (in_tdata[4:0]),
    .first_of_sequence (in_tuser[3]),
    .table_index       (in_tdata[20:5]),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .read_value        (read_value),
    .overflow_total    (overflow_total),
    .cmd               (cmd),
    .sts               (sts)
  );

  assign out_tdata = {overflow_total, read_value};

endmodule

### rtl/kmc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmc_ctrl
// sequencer: table clear, symbol phases (seed, context, transition), reads
// ---------------------------------------------------------------------------
module kmc_ctrl
  import kmc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_START = 6'b000100,
    S_WALK  = 6'b001000,
    S_UPD   = 6'b010000,
    S_READ  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  state_t adv_state;
  phase_t adv_phase;
  logic   need;

  always_comb begin
    adv_state = S_START;
    adv_phase = phase_r;
    unique case (phase_r)
      PH_SEED: adv_phase = PH_CTX;
      PH_CTX:  adv_phase = PH_TR;
      default: adv_state = S_IDLE;
    endcase
    unique case (phase_r)
      PH_SEED: need = sts.need_seed;
      PH_CTX:  need = sts.need_ctx;
      default: need = sts.need_tr;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.phase = phase_r;
    state_nxt = state_r;
    phase_nxt = phase_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (sts.req_sym) begin
            cmd.take_sym = 1'b1;
            if (sts.sym_ok) begin
              state_nxt = S_START;
              phase_nxt = PH_SEED;
            end
          end else if (sts.req_read) begin
            cmd.rd_req = 1'b1;
            state_nxt  = S_READ;
          end
        end
      end
      S_START: begin
        if (need) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK;
        end else begin
          state_nxt = adv_state;
          phase_nxt = adv_phase;
        end
      end
      S_WALK: begin
        if (sts.walk_hit) begin
          cmd.ovf_bump = 1'b1;
          state_nxt    = adv_state;
          phase_nxt    = adv_phase;
        end else if (sts.walk_done) begin
          cmd.tbl_rd = 1'b1;
          state_nxt  = S_UPD;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_UPD: begin
        cmd.tbl_wr = 1'b1;
        state_nxt  = adv_state;
        phase_nxt  = adv_phase;
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      phase_r <= PH_SEED;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

### rtl/kmc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmc_datapath
// symbol window, k-mer code unit, count tables, totals and result register
// ---------------------------------------------------------------------------
module kmc_datapath
  import kmc_pkg::*;
#(
  parameter int SEED_TABLE_DEPTH       = 65536,
  parameter int CONTEXT_TABLE_DEPTH    = 1024,
  parameter int TRANSITION_TABLE_DEPTH = 1024,
  parameter int MAX_SEED_LENGTH        = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFGA_W-1:0]       cfg_addr,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic [REQ_W-1:0]        req_type,
  input  logic [SYM_W-1:0]        symbol,
  input  logic                    first_of_sequence,
  input  logic [IDX_W-1:0]        table_index,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [VAL_W-1:0]        read_value,
  output logic [OVF_W-1:0]        overflow_total,
  input  cmd_t                    cmd,
  output sts_t                    sts
);

  localparam int WIN   = MAX_SEED_LENGTH + 4;
  localparam int CW    = $clog2(WIN + 1);
  localparam int WW    = $clog2(WIN);
  localparam int SAW   = $clog2(SEED_TABLE_DEPTH);
  localparam int CAW   = $clog2(CONTEXT_TABLE_DEPTH);
  localparam int TAW   = $clog2(TRANSITION_TABLE_DEPTH);
  localparam int MAXD0 = (CONTEXT_TABLE_DEPTH > TRANSITION_TABLE_DEPTH) ?
                         CONTEXT_TABLE_DEPTH : TRANSITION_TABLE_DEPTH;
  localparam int MAXD  = (SEED_TABLE_DEPTH > MAXD0) ? SEED_TABLE_DEPTH : MAXD0;
  localparam int DW    = $clog2(MAXD) + 1;
  localparam int NW    = DW + 6;
  localparam int CLW   = $clog2(MAXD);

  // configuration
  logic [5:0] alpha_r;
  logic [4:0] slen_cfg_r;
  logic [1:0] ord_cfg_r;
  logic [5:0] radix;
  logic [CW-1:0] slen, ord, ord1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= 6'd4;
      slen_cfg_r <= 5'd8;
      ord_cfg_r  <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ALPHABET: alpha_r    <= cfg_wdata;
        CFG_SEEDLEN:  slen_cfg_r <= cfg_wdata[4:0];
        CFG_ORDER:    ord_cfg_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (alpha_r < 6'd2)       radix = 6'd2;
    else if (alpha_r > 6'd32) radix = 6'd32;
    else                      radix = alpha_r;
    if (slen_cfg_r == 5'd0)                              slen = CW'(1);
    else if (CW'(slen_cfg_r) > CW'(MAX_SEED_LENGTH))     slen = CW'(MAX_SEED_LENGTH);
    else                                                 slen = CW'(slen_cfg_r);
    ord  = (ord_cfg_r == 2'd0) ? CW'(1) : CW'(ord_cfg_r);
    ord1 = ord + CW'(1);
  end

  // window and sequence state
  logic [SYM_W-1:0] win_r [WIN];
  logic [CW-1:0]    fill_r, fill_base;
  logic [SEQ_W-1:0] seq_r;
  logic             seq_start, sym_ok;

  assign sym_ok    = {1'b0, symbol} < radix;
  assign seq_start = first_of_sequence || (seq_r == '0);
  assign fill_base = seq_start ? '0 : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      seq_r  <= '0;
      for (int i = 0; i < WIN; i++) win_r[i] <= '0;
    end else if (cmd.take_sym) begin
      if (seq_start) seq_r <= (seq_r == '1) ? SEQ_W'(1) : seq_r + SEQ_W'(1);
      if (sym_ok) begin
        for (int i = WIN - 1; i > 0; i--) win_r[i] <= win_r[i-1];
        win_r[0] <= symbol;
        fill_r   <= (fill_base == CW'(WIN)) ? fill_base : fill_base + CW'(1);
      end else begin
        fill_r <= fill_base;
      end
    end
  end

  // k-mer code unit, one symbol per step, oldest first
  phase_t        ph_r;
  logic [CW-1:0] cnt_r, cnt_m1;
  logic [DW-1:0] code_r;
  logic          hit_r;
  logic [NW-1:0] nc, depth_sel;
  logic [CW-1:0] k_sel;

  assign cnt_m1 = cnt_r - CW'(1);
  assign nc     = NW'(code_r) * NW'(radix) + NW'(win_r[cnt_m1[WW-1:0]]);

  always_comb begin
    unique case (ph_r)
      PH_SEED: depth_sel = NW'(SEED_TABLE_DEPTH);
      PH_CTX:  depth_sel = NW'(CONTEXT_TABLE_DEPTH);
      default: depth_sel = NW'(TRANSITION_TABLE_DEPTH);
    endcase
    unique case (cmd.phase)
      PH_SEED: k_sel = slen;
      PH_CTX:  k_sel = ord;
      default: k_sel = ord1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_SEED;
      cnt_r <= '0;
      hit_r <= 1'b0;
    end else if (cmd.walk_start) begin
      ph_r  <= cmd.phase;
      cnt_r <= k_sel;
      hit_r <= 1'b0;
    end else if (cmd.walk_step) begin
      cnt_r <= cnt_m1;
      hit_r <= nc >= depth_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start)     code_r <= '0;
    else if (cmd.walk_step) code_r <= nc[DW-1:0];
  end

  // totals
  logic [VAL_W-1:0] sum_r;
  logic [OVF_W-1:0] ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      ovf_r <= '0;
    end else begin
      if (cmd.ovf_bump && ovf_r != '1) ovf_r <= ovf_r + OVF_W'(1);
      if (cmd.tbl_wr && ph_r == PH_CTX && sum_r != '1) sum_r <= sum_r + VAL_W'(1);
    end
  end

  // clearing pass
  logic [CLW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n)            clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + CLW'(1);
  end

  // memories
  logic [31:0] idx_ext, clr_ext;
  logic        rd_en;
  assign idx_ext = {16'd0, table_index};
  assign clr_ext = 32'(clr_r);
  assign rd_en   = cmd.rd_req | cmd.tbl_rd;

  logic [SUP_W-1:0]   sup_mem  [SEED_TABLE_DEPTH];
  logic [SEQ_W-1:0]   last_mem [SEED_TABLE_DEPTH];
  logic [CNT32_W-1:0] ctx_mem  [CONTEXT_TABLE_DEPTH];
  logic [CNT32_W-1:0] tr_mem   [TRANSITION_TABLE_DEPTH];

  logic [SUP_W-1:0]   sup_q_r;
  logic [SEQ_W-1:0]   last_q_r;
  logic [CNT32_W-1:0] ctx_q_r, tr_q_r;

  logic [SAW-1:0] s_ra, s_wa;
  logic [CAW-1:0] c_ra, c_wa;
  logic [TAW-1:0] t_ra, t_wa;
  logic           s_we, c_we, t_we;
  logic [SUP_W-1:0]   sup_wd;
  logic [SEQ_W-1:0]   last_wd;
  logic [CNT32_W-1:0] ctx_wd, tr_wd;

  always_comb begin
    s_ra = cmd.rd_req ? idx_ext[SAW-1:0] : code_r[SAW-1:0];
    c_ra = cmd.rd_req ? idx_ext[CAW-1:0] : code_r[CAW-1:0];
    t_ra = cmd.rd_req ? idx_ext[TAW-1:0] : code_r[TAW-1:0];
    if (cmd.clr_step) begin
      s_we    = clr_ext < 32'(SEED_TABLE_DEPTH);
      c_we    = clr_ext < 32'(CONTEXT_TABLE_DEPTH);
      t_we    = clr_ext < 32'(TRANSITION_TABLE_DEPTH);
      s_wa    = clr_r[SAW-1:0];
      c_wa    = clr_r[CAW-1:0];
      t_wa    = clr_r[TAW-1:0];
      sup_wd  = '0;
      last_wd = '0;
      ctx_wd  = '0;
      tr_wd   = '0;
    end else begin
      s_we    = cmd.tbl_wr && ph_r == PH_SEED;
      c_we    = cmd.tbl_wr && ph_r == PH_CTX;
      t_we    = cmd.tbl_wr && ph_r == PH_TR;
      s_wa    = code_r[SAW-1:0];
      c_wa    = code_r[CAW-1:0];
      t_wa    = code_r[TAW-1:0];
      last_wd = seq_r;
      sup_wd  = (last_q_r != seq_r && sup_q_r != '1) ? sup_q_r + SUP_W'(1) : sup_q_r;
      ctx_wd  = (ctx_q_r != '1) ? ctx_q_r + CNT32_W'(1) : ctx_q_r;
      tr_wd   = (tr_q_r != '1) ? tr_q_r + CNT32_W'(1) : tr_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sup_mem[s_wa]  <= sup_wd;
      last_mem[s_wa] <= last_wd;
    end
    if (rd_en) begin
      sup_q_r  <= sup_mem[s_ra];
      last_q_r <= last_mem[s_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we)  ctx_mem[c_wa] <= ctx_wd;
    if (rd_en) ctx_q_r <= ctx_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (t_we)  tr_mem[t_wa] <= tr_wd;
    if (rd_en) tr_q_r <= tr_mem[t_ra];
  end

  // read request capture and result register
  logic [REQ_W-1:0] kind_r;
  logic             in_rng_r;
  logic             in_rng;
  logic [VAL_W-1:0] sel_val;
  logic             ov_r;
  logic [VAL_W-1:0] val_r;
  logic [OVF_W-1:0] ovo_r;

  always_comb begin
    unique case (req_type)
      REQ_SUPPORT: in_rng = idx_ext < 32'(SEED_TABLE_DEPTH);
      REQ_CONTEXT: in_rng = idx_ext < 32'(CONTEXT_TABLE_DEPTH);
      REQ_TRANS:   in_rng = idx_ext < 32'(TRANSITION_TABLE_DEPTH);
      default:     in_rng = 1'b1;
    endcase
    unique case (kind_r)
      REQ_SUPPORT: sel_val = in_rng_r ? VAL_W'(sup_q_r) : '0;
      REQ_CONTEXT: sel_val = in_rng_r ? VAL_W'(ctx_q_r) : '0;
      REQ_TRANS:   sel_val = in_rng_r ? VAL_W'(tr_q_r) : '0;
      default:     sel_val = sum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_req) begin
      kind_r   <= req_type;
      in_rng_r <= in_rng;
    end
    if (cmd.out_load) begin
      val_r <= sel_val;
      ovo_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            ov_r <= 1'b0;
    else if (cmd.out_load) ov_r <= 1'b1;
    else if (out_tready)   ov_r <= 1'b0;
  end

  assign out_tvalid     = ov_r;
  assign read_value     = val_r;
  assign overflow_total = ovo_r;

  // status
  always_comb begin
    sts           = '0;
    sts.clr_done  = clr_r == CLW'(MAXD - 1);
    sts.req_sym   = req_type == REQ_SYMBOL;
    sts.req_read  = req_type == REQ_SUPPORT || req_type == REQ_CONTEXT ||
                    req_type == REQ_TRANS || req_type == REQ_TOTALS;
    sts.sym_ok    = sym_ok;
    sts.need_seed = fill_r >= slen;
    sts.need_ctx  = fill_r >= ord;
    sts.need_tr   = fill_r >= ord1;
    sts.walk_hit  = hit_r;
    sts.walk_done = (cnt_r == '0) && !hit_r;
    sts.out_free  = !ov_r || out_tready;
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stream test of the k-mer seed support and markov counter: a predictor
// tracks window, tables and totals for every symbol, read results are
// compared field by field under random idling and output back-pressure
// ---------------------------------------------------------------------------
module tb_top
  import kmc_pkg::*;
();

  localparam int SEED_DEPTH = 65536;
  localparam int CTX_DEPTH  = 1024;
  localparam int TR_DEPTH   = 1024;
  localparam int MAX_SLEN   = 16;
  localparam int WSLOTS     = MAX_SLEN + 4;
  localparam logic [39:0] SUM_SAT = 40'hFF_FFFF_FFFF;
  localparam int IDLE_LIMIT = 300000;

  typedef struct packed {
    logic [39:0] value;
    logic [31:0] ovf;
  } read_result_t;

  class kmer_scoreboard;
    bit [5:0] radix_reg;
    bit [4:0] slen_reg;
    bit [1:0] order_reg;
    bit [4:0] win[WSLOTS];
    int unsigned fill;
    int unsigned seq_no;
    bit [15:0] support[SEED_DEPTH];
    bit [15:0] last_seen[SEED_DEPTH];
    bit [31:0] ctx_cnt[CTX_DEPTH];
    bit [31:0] tr_cnt[TR_DEPTH];
    bit [39:0] ctx_sum;
    bit [31:0] ovf_cnt;
    read_result_t pending_reads[$];
    int errors;

    function new();
      radix_reg = 4;
      slen_reg = 8;
      order_reg = 3;
      fill = 0;
      seq_no = 0;
      ctx_sum = 0;
      ovf_cnt = 0;
      errors = 0;
      foreach (win[i]) win[i] = 0;
      foreach (support[i]) begin
        support[i] = 0;
        last_seen[i] = 0;
      end
      foreach (ctx_cnt[i]) begin
        ctx_cnt[i] = 0;
        tr_cnt[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFGA_W-1:0] addr, bit [5:0] val);
      case (addr)
        CFG_ALPHABET: radix_reg = val;
        CFG_SEEDLEN:  slen_reg = val[4:0];
        CFG_ORDER:    order_reg = val[1:0];
        default: ;
      endcase
    endfunction

    function bit kmer_code(int unsigned k, int unsigned radix, longint unsigned depth,
                           output longint unsigned code);
      longint unsigned c;
      c = 0;
      code = 0;
      for (int i = k; i > 0; i--) begin
        c = c * radix + win[(i - 1) % WSLOTS];
        if (c >= depth) return 0;
      end
      code = c;
      return 1;
    endfunction

    function void bump_ovf();
      if (ovf_cnt != 32'hFFFF_FFFF) ovf_cnt++;
    endfunction

    function void shift_symbol(bit [4:0] sym, bit first);
      int unsigned radix, slen, ord;
      longint unsigned code;
      radix = radix_reg < 2 ? 2 : (radix_reg > 32 ? 32 : radix_reg);
      slen = slen_reg < 1 ? 1 : (slen_reg > MAX_SLEN ? MAX_SLEN : slen_reg);
      ord = order_reg < 1 ? 1 : order_reg;
      if (first || seq_no == 0) begin
        seq_no = (seq_no >= 16'hFFFF) ? 1 : seq_no + 1;
        fill = 0;
      end
      if (sym >= radix) return;
      for (int i = WSLOTS - 1; i > 0; i--) win[i] = win[i - 1];
      win[0] = sym;
      if (fill < WSLOTS) fill++;
      if (fill >= slen) begin
        if (kmer_code(slen, radix, SEED_DEPTH, code)) begin
          if (last_seen[code] != seq_no[15:0]) begin
            last_seen[code] = seq_no[15:0];
            if (support[code] != 16'hFFFF) support[code]++;
          end
        end else bump_ovf();
      end
      if (fill >= ord) begin
        if (kmer_code(ord, radix, CTX_DEPTH, code)) begin
          if (ctx_cnt[code] != 32'hFFFF_FFFF) ctx_cnt[code]++;
          if (ctx_sum < SUM_SAT) ctx_sum++;
        end else bump_ovf();
      end
      if (fill >= ord + 1) begin
        if (kmer_code(ord + 1, radix, TR_DEPTH, code)) begin
          if (tr_cnt[code] != 32'hFFFF_FFFF) tr_cnt[code]++;
        end else bump_ovf();
      end
    endfunction

    function void note_input(logic [REQ_W-1:0] req, bit [4:0] sym, bit first,
                             bit [15:0] idx);
      read_result_t r;
      r.value = 0;
      r.ovf = 0;
      case (req)
        REQ_SYMBOL: begin
          shift_symbol(sym, first);
          return;
        end
        REQ_SUPPORT: if (idx < SEED_DEPTH) r.value = support[idx];
        REQ_CONTEXT: if (idx < CTX_DEPTH) r.value = ctx_cnt[idx];
        REQ_TRANS:   if (idx < TR_DEPTH) r.value = tr_cnt[idx];
        REQ_TOTALS:  r.value = ctx_sum;
        default: return;
      endcase
      r.ovf = ovf_cnt;
      pending_reads = {pending_reads, r};
    endfunction

    task report(string what, logic [39:0] exp_v, logic [39:0] got_v);
      errors++;
      $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    endtask

    task check_result(read_result_t got);
      read_result_t exp_r;
      if (pending_reads.size() == 0) begin
        report("unexpected result", 0, got.value);
        return;
      end
      exp_r = pending_reads.pop_front();
      if (got.value !== exp_r.value) report("read_value", exp_r.value, got.value);
      if (got.ovf !== exp_r.ovf) report("overflow_total", exp_r.ovf, got.ovf);
    endtask
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [CFGA_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;  // symbol, table_index, zero pad
  logic [3:0]        in_tuser = '0;  // req_type, first_of_sequence
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [71:0]       out_tdata;      // read_value, overflow_total

  kmer_scoreboard sb;
  int send_idle_pct = 16;
  int recv_idle_pct = 64;
  bit hold_off = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  kmer_support_markov_counter_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      read_result_t r;
      r.value = out_tdata[39:0];
      r.ovf = out_tdata[71:40];
      sb.check_result(r);
    end
    if (rst_n) out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(logic [REQ_W-1:0] req, bit [4:0] sym, bit first, bit [15:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {3'b0, idx, sym};
    in_tuser <= {first, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(req, sym, first, idx);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFGA_W-1:0] addr, bit [5:0] val);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(addr, val);
  endtask

  task automatic set_cfg(bit [5:0] radix, bit [5:0] slen, bit [5:0] ord);
    drain();
    write_cfg(CFG_ALPHABET, radix);
    write_cfg(CFG_SEEDLEN, slen);
    write_cfg(CFG_ORDER, ord);
  endtask

  task automatic random_read();
    int k;
    bit [15:0] idx;
    k = $urandom_range(3);
    idx = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1100));
    case (k)
      0: send(REQ_SUPPORT, 5'($urandom), 0, idx);
      1: send(REQ_CONTEXT, 5'($urandom), 0, idx);
      2: send(REQ_TRANS, 5'($urandom), 0, idx);
      default: send(REQ_TOTALS, 5'($urandom), 1'($urandom), idx);
    endcase
  endtask

  task automatic random_phase(int n, int radix);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 65)
        send(REQ_SYMBOL, $urandom_range(9) == 0 ? 5'($urandom) : 5'($urandom_range(radix - 1)),
             $urandom_range(11) == 0, 16'($urandom));
      else if (r < 97) random_read();
      else send(3'($urandom_range(7, 5)), 5'($urandom), 1'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reads of empty tables, symbol before any sequence start
    send(REQ_TOTALS, 0, 0, 0);
    send(REQ_SUPPORT, 0, 0, 16'hFFFF);
    send(REQ_SYMBOL, 5'd1, 0, 0);
    send(REQ_SYMBOL, 5'd31, 0, 0);
    for (int i = 0; i < 9; i++) send(REQ_SYMBOL, 5'(i % 4), i == 4, 16'hFFFF);
    send(REQ_CONTEXT, 0, 0, 16'd6);
    send(REQ_TRANS, 0, 0, 16'd27);
    send(REQ_TRANS, 0, 0, 16'd1024);
    send(REQ_CONTEXT, 0, 0, 16'd1023);
    send(3'd7, 5'd3, 1, 0);
    send(REQ_TOTALS, 5'd31, 1, 16'hFFFF);

    // extremes: radix 32 overflows seed, context and transition tables
    set_cfg(6'd32, 6'd16, 6'd3);
    for (int i = 0; i < 20; i++) send(REQ_SYMBOL, 5'd31 - 5'(i % 3), i == 0, 0);
    send(REQ_TOTALS, 0, 0, 0);
    set_cfg(6'd0, 6'd0, 6'd0);
    for (int i = 0; i < 10; i++) send(REQ_SYMBOL, 5'(i % 3), i == 5, 0);
    send(REQ_SUPPORT, 0, 0, 1);
    send(REQ_CONTEXT, 0, 0, 1);

    // phase 1: sender idles 16, receiver 64, with long receiver hold-off
    set_cfg(6'd4, 6'd5, 6'd3);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        random_phase(60, 4);
        in_tvalid <= 0;
      end
    join
    random_phase(300, 4);
    set_cfg(6'd2, 6'd1, 6'd1);
    random_phase(150, 2);

    send_idle_pct = 64;
    recv_idle_pct = 16;
    set_cfg(6'd20, 6'd3, 6'd2);
    random_phase(300, 20);
    set_cfg(6'd63, 6'd31, 6'd3);
    random_phase(150, 32);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_cfg(6'd3, 6'd10, 6'd2);
    random_phase(300, 3);
    drain();

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
